// ===== sv/rtmb_pkg.sv =====
package rtmb_pkg;

   localparam int unsigned BLOCK_SIDE       = 8;
   localparam int unsigned MAX_H_FACTOR     = 4;
   localparam int unsigned DEF_MAX_WIDTH    = 2048;
   localparam int unsigned DEF_MAX_V_FACTOR = 4;

   localparam logic [11:0] RESET_WIDTH    = 12'd8;
   localparam logic [15:0] RESET_HEIGHT   = 16'd8;
   localparam logic [2:0]  RESET_H_FACTOR = 3'd1;
   localparam logic [2:0]  RESET_V_FACTOR = 3'd1;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_FETCH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_DELIVERED = 2'd1,
      ST_NOT_READY = 2'd2,
      ST_REFUSED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_H_FACTOR     = 2'd2,
      REG_V_FACTOR     = 2'd3
   } csr_index_type;

   // everything about a result except the pixel read from the store
   typedef struct packed {
      status_type  status;
      logic [3:0]  block_number;
      logic        end_of_block;
      logic        end_of_mcu;
      logic        end_of_image;
   } rsp_meta_type;

   typedef struct packed {
      rsp_meta_type meta;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
   } rsp_word_type;

endpackage

// ===== sv/raster_to_mcu_block_reorder.sv =====
// A result word goes through the result stage (store read) and then the output buffer
// before it is offered.
// Throughput: one word per cycle, writes and fetches alike, while the output buffer
// has room; the single-port strip store does one read or one write per cycle.
// Reset: counters, phase and the output buffer clear and the registers take their
// defaults; the strip store is not cleared, there is no clearing pass.
module raster_to_mcu_block_reorder
   import rtmb_pkg::*;
#(
   parameter int unsigned MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int unsigned MAX_V_FACTOR = DEF_MAX_V_FACTOR
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [3:0]  rsp_block_number,
   output logic        rsp_end_of_block,
   output logic        rsp_end_of_mcu,
   output logic        rsp_end_of_image,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned STRIP_ROWS = BLOCK_SIDE * MAX_V_FACTOR;
   localparam int unsigned CW         = $clog2(MAX_WIDTH);
   localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW         = $clog2(STRIP_ROWS);
   localparam int unsigned SRW        = $clog2(STRIP_ROWS + 1);
   localparam int unsigned AW         = RW + CW;
   localparam int unsigned DEPTH      = 1 << AW;
   localparam int unsigned MCU_MAX    = (MAX_WIDTH + BLOCK_SIDE - 1) / BLOCK_SIDE;
   localparam int unsigned MCW        = $clog2(MCU_MAX + 1);
   localparam int unsigned BRW        = (MAX_V_FACTOR > 1) ? $clog2(MAX_V_FACTOR) : 1;
   localparam int unsigned XW         = MCW + 6;
   localparam int unsigned YW         = BRW + 3;
   localparam logic [2:0]  PIX_LAST   = 3'(BLOCK_SIDE - 1);

   // ---------------- configuration registers ----------------
   logic [11:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [2:0]  h_factor_ff;
   logic [2:0]  v_factor_ff;
   logic        csr_we;
   csr_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_we    = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RESET_WIDTH;
         image_height_ff <= RESET_HEIGHT;
         h_factor_ff     <= RESET_H_FACTOR;
         v_factor_ff     <= RESET_V_FACTOR;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[11:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[15:0];
            REG_H_FACTOR:     h_factor_ff     <= pwdata[2:0];
            REG_V_FACTOR:     v_factor_ff     <= pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_IMAGE_WIDTH:  prdata = 32'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = 32'(image_height_ff);
         REG_H_FACTOR:     prdata = 32'(h_factor_ff);
         REG_V_FACTOR:     prdata = 32'(v_factor_ff);
         default:          prdata = '0;
      endcase
   end

   // effective (clamped) settings
   logic [WW-1:0] w_eff;
   logic [15:0]   height_eff;
   logic [2:0]    h_eff;
   logic [2:0]    v_eff;

   always_comb begin
      if (image_width_ff == 12'd0) w_eff = WW'(1);
      else if (32'(image_width_ff) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
      else w_eff = WW'(image_width_ff);

      height_eff = (image_height_ff == 16'd0) ? 16'd1 : image_height_ff;

      if (h_factor_ff == 3'd0) h_eff = 3'd1;
      else if (32'(h_factor_ff) > MAX_H_FACTOR) h_eff = 3'(MAX_H_FACTOR);
      else h_eff = h_factor_ff;

      if (v_factor_ff == 3'd0) v_eff = 3'd1;
      else if (32'(v_factor_ff) > MAX_V_FACTOR) v_eff = 3'(MAX_V_FACTOR);
      else v_eff = v_factor_ff;
   end

   // ---------------- sequencing state ----------------
   logic [CW-1:0]  write_column_ff,    write_column_in;
   logic [SRW-1:0] strip_row_count_ff, strip_row_count_in;
   logic [15:0]    image_row_count_ff, image_row_count_in;
   logic           read_phase_ff,      read_phase_in;
   logic [MCW-1:0] mcu_column_ff,      mcu_column_in;
   logic [BRW-1:0] block_row_ff,       block_row_in;
   logic [1:0]     block_column_ff,    block_column_in;
   logic [2:0]     pixel_row_ff,       pixel_row_in;
   logic [2:0]     pixel_column_ff,    pixel_column_in;

   logic accept;
   logic is_fetch;
   logic mem_we;
   logic mem_re;

   assign accept   = req_valid && req_ready;
   assign is_fetch = (req_cmd == CMD_FETCH);
   assign mem_we   = accept && !is_fetch && !read_phase_ff;
   assign mem_re   = accept && is_fetch && read_phase_ff;

   // write side address and counters
   logic [CW-1:0]  wcol;
   logic [RW-1:0]  wrow;
   logic [WW-1:0]  wcol_inc;
   logic [SRW-1:0] srow_inc;
   logic [15:0]    irow_inc;
   logic           row_done;
   logic           strip_full;

   always_comb begin
      wcol = (WW'(write_column_ff) < w_eff) ? write_column_ff : CW'(w_eff - WW'(1));
      wrow = (32'(strip_row_count_ff) < STRIP_ROWS) ? RW'(strip_row_count_ff)
                                                     : RW'(STRIP_ROWS - 1);
      wcol_inc   = WW'(write_column_ff) + WW'(1);
      row_done   = (wcol_inc >= w_eff);
      srow_inc   = strip_row_count_ff + SRW'(1);
      irow_inc   = image_row_count_ff + 16'd1;
      strip_full = (32'(srow_inc) >= BLOCK_SIDE * 32'(v_eff)) || (irow_inc >= height_eff);
   end

   // read side address and counters
   logic [XW-4:0]  mcu_prod;
   logic [XW-1:0]  mcu_base;
   logic [XW-1:0]  mcu_next_base;
   logic [XW-1:0]  x_raw;
   logic [CW-1:0]  rcol;
   logic [SRW-1:0] rows_eff;
   logic [YW-1:0]  y_raw;
   logic [RW-1:0]  rrow;
   logic [3:0]     block_num;
   logic [2:0]     bc_inc;
   logic [BRW:0]   br_inc;
   logic           eob;
   logic           bc_wrap;
   logic           br_wrap;
   logic           eom;
   logic           strip_end;
   logic           eoi;

   always_comb begin
      mcu_prod      = (XW - 3)'(mcu_column_ff) * (XW - 3)'(h_eff);
      mcu_base      = {mcu_prod, 3'b000};
      mcu_next_base = mcu_base + XW'({h_eff, 3'b000});
      x_raw         = mcu_base + XW'({block_column_ff, 3'b000}) + XW'(pixel_column_ff);
      // padding on the right: repeat the last column
      rcol = (32'(x_raw) > 32'(w_eff) - 32'd1) ? CW'(w_eff - WW'(1)) : CW'(x_raw);
      rows_eff = (strip_row_count_ff == '0) ? SRW'(1) : strip_row_count_ff;
      y_raw    = {block_row_ff, pixel_row_ff};
      // padding at the bottom: repeat the last written row
      rrow = (32'(y_raw) > 32'(rows_eff) - 32'd1) ? RW'(rows_eff - SRW'(1)) : RW'(y_raw);

      block_num = 4'(4'(block_row_ff) * 4'(h_eff) + 4'(block_column_ff));
      bc_inc    = 3'(block_column_ff) + 3'd1;
      br_inc    = (BRW + 1)'(block_row_ff) + (BRW + 1)'(1);
      eob       = (pixel_column_ff == PIX_LAST) && (pixel_row_ff == PIX_LAST);
      bc_wrap   = (bc_inc >= h_eff);
      br_wrap   = (32'(br_inc) >= 32'(v_eff));
      eom       = eob && bc_wrap && br_wrap;
      strip_end = eom && (32'(mcu_next_base) >= 32'(w_eff));
      eoi       = strip_end && (image_row_count_ff >= height_eff);
   end

   always_comb begin
      write_column_in    = write_column_ff;
      strip_row_count_in = strip_row_count_ff;
      image_row_count_in = image_row_count_ff;
      read_phase_in      = read_phase_ff;
      mcu_column_in      = mcu_column_ff;
      block_row_in       = block_row_ff;
      block_column_in    = block_column_ff;
      pixel_row_in       = pixel_row_ff;
      pixel_column_in    = pixel_column_ff;

      if (mem_we) begin
         write_column_in = row_done ? '0 : CW'(wcol_inc);
         if (row_done) begin
            strip_row_count_in = srow_inc;
            image_row_count_in = irow_inc;
            if (strip_full) begin
               read_phase_in   = 1'b1;
               mcu_column_in   = '0;
               block_row_in    = '0;
               block_column_in = '0;
               pixel_row_in    = '0;
               pixel_column_in = '0;
            end
         end
      end

      if (mem_re) begin
         pixel_column_in = pixel_column_ff + 3'd1;
         if (pixel_column_ff == PIX_LAST) begin
            pixel_row_in = pixel_row_ff + 3'd1;
            if (eob) begin
               block_column_in = bc_wrap ? 2'd0 : 2'(bc_inc);
               if (bc_wrap) begin
                  block_row_in = br_wrap ? '0 : BRW'(br_inc);
                  if (br_wrap) begin
                     mcu_column_in = strip_end ? '0 : mcu_column_ff + MCW'(1);
                     if (strip_end) begin
                        read_phase_in      = 1'b0;
                        strip_row_count_in = '0;
                        write_column_in    = '0;
                        if (eoi) image_row_count_in = '0;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_column_ff    <= '0;
         strip_row_count_ff <= '0;
         image_row_count_ff <= '0;
         read_phase_ff      <= 1'b0;
         mcu_column_ff      <= '0;
         block_row_ff       <= '0;
         block_column_ff    <= '0;
         pixel_row_ff       <= '0;
         pixel_column_ff    <= '0;
      end else begin
         write_column_ff    <= write_column_in;
         strip_row_count_ff <= strip_row_count_in;
         image_row_count_ff <= image_row_count_in;
         read_phase_ff      <= read_phase_in;
         mcu_column_ff      <= mcu_column_in;
         block_row_ff       <= block_row_in;
         block_column_ff    <= block_column_in;
         pixel_row_ff       <= pixel_row_in;
         pixel_column_ff    <= pixel_column_in;
      end
   end

   // ---------------- strip store ----------------
   logic [23:0]   strip_mem [DEPTH];
   logic [23:0]   rdata_ff;
   logic [AW-1:0] mem_addr;

   assign mem_addr = is_fetch ? {rrow, rcol} : {wrow, wcol};

   always_ff @(posedge clock) begin
      if (mem_we) strip_mem[mem_addr] <= {req_red_in, req_green_in, req_blue_in};
      if (mem_re) rdata_ff <= strip_mem[mem_addr];
   end

   // ---------------- result stage and output buffer ----------------
   rsp_meta_type meta_new;

   always_comb begin
      meta_new = '0;
      if (is_fetch) begin
         if (read_phase_ff) begin
            meta_new.status       = ST_DELIVERED;
            meta_new.block_number = block_num;
            meta_new.end_of_block = eob;
            meta_new.end_of_mcu   = eom;
            meta_new.end_of_image = eoi;
         end else begin
            meta_new.status = ST_NOT_READY;
         end
      end else begin
         meta_new.status = read_phase_ff ? ST_REFUSED : ST_ACCEPTED;
      end
   end

   logic         s1_valid_ff, s1_valid_in;
   rsp_meta_type s1_meta_ff;
   logic         s1_move;
   rsp_word_type push_word;

   rsp_word_type fifo_mem [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fifo_count_ff, fifo_count_in;
   logic         push;
   logic         pop;
   rsp_word_type head;

   // ready depends on registers only: room for one more word in flight
   assign req_ready = (2'(s1_valid_ff) + fifo_count_ff) <= 2'd2;

   assign pop     = rsp_valid && rsp_ready;
   assign s1_move = s1_valid_ff && ((fifo_count_ff < 2'd2) || pop);
   assign push    = s1_move;

   always_comb begin
      push_word.meta  = s1_meta_ff;
      push_word.red   = '0;
      push_word.green = '0;
      push_word.blue  = '0;
      if (s1_meta_ff.status == ST_DELIVERED) begin
         {push_word.red, push_word.green, push_word.blue} = rdata_ff;
      end
      s1_valid_in   = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      wr_ptr_in     = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = pop ? !rd_ptr_ff : rd_ptr_ff;
      fifo_count_in = fifo_count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
         fifo_count_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_meta_ff <= meta_new;
      if (push) fifo_mem[wr_ptr_ff] <= push_word;
   end

   assign head             = fifo_mem[rd_ptr_ff];
   assign rsp_valid        = (fifo_count_ff != 2'd0);
   assign rsp_status       = head.meta.status;
   assign rsp_red_out      = head.red;
   assign rsp_green_out    = head.green;
   assign rsp_blue_out     = head.blue;
   assign rsp_block_number = head.meta.block_number;
   assign rsp_end_of_block = head.meta.end_of_block;
   assign rsp_end_of_mcu   = head.meta.end_of_mcu;
   assign rsp_end_of_image = head.meta.end_of_image;

   // ---------------- assertions ----------------
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> fifo_count_ff < 2'd2)
      else $error("output buffer overflow");

   a_read_phase_after_write: assert property (@(posedge clock) disable iff (reset)
      $rose(read_phase_ff) |-> $past(mem_we))
      else $error("read phase entered without a pixel write");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word lost before the result stage");

   a_marks_nested: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_end_of_image || rsp_end_of_mcu) |-> rsp_end_of_block
         && (rsp_end_of_mcu || !rsp_end_of_image))
      else $error("end marks out of order");

   a_zero_unless_delivered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_DELIVERED) |->
         rsp_red_out == 8'd0 && rsp_green_out == 8'd0 && rsp_blue_out == 8'd0
         && rsp_block_number == 4'd0 && !rsp_end_of_block)
      else $error("nonzero payload on a status-only word");

endmodule

// ===== sim/raster_to_mcu_block_reorder_tb.sv =====
module raster_to_mcu_block_reorder_tb;
   import rtmb_pkg::*;

   localparam int unsigned STRIP_ROWS   = BLOCK_SIDE * DEF_MAX_V_FACTOR;
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [7:0]  req_red_in;
   logic [7:0]  req_green_in;
   logic [7:0]  req_blue_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [3:0]  rsp_block_number;
   logic        rsp_end_of_block;
   logic        rsp_end_of_mcu;
   logic        rsp_end_of_image;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   raster_to_mcu_block_reorder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_block_number (rsp_block_number),
      .rsp_end_of_block (rsp_end_of_block),
      .rsp_end_of_mcu   (rsp_end_of_mcu),
      .rsp_end_of_image (rsp_end_of_image),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // shadow registers and reorder state
   logic [11:0]  img_width_reg  = RESET_WIDTH;
   logic [15:0]  img_height_reg = RESET_HEIGHT;
   logic [2:0]   h_factor_reg   = RESET_H_FACTOR;
   logic [2:0]   v_factor_reg   = RESET_V_FACTOR;
   logic [23:0]  strip_mem [DEF_MAX_WIDTH * STRIP_ROWS];
   int unsigned  wr_col      = 0;
   int unsigned  strip_rows  = 0;
   logic [15:0]  img_rows    = '0;
   logic         reading     = 1'b0;
   int unsigned  mcu_col     = 0;
   int unsigned  blk_row     = 0;
   int unsigned  blk_col     = 0;
   int unsigned  pix_row     = 0;
   int unsigned  pix_col     = 0;
   int unsigned  images_done = 0;

   rsp_word_type expected_words[$];
   int unsigned  errors       = 0;
   int unsigned  items_sent   = 0;
   int unsigned  cycle_count  = 0;
   int unsigned  burst_left   = 0;
   int unsigned  hold_cycles  = 0;
   logic         sender_idles = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("raster_to_mcu_block_reorder test failed");
         $finish;
      end
   end

   function automatic int unsigned active_width();
      if (img_width_reg == 0) return 1;
      if (img_width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return img_width_reg;
   endfunction

   function automatic int unsigned active_height();
      if (img_height_reg == 0) return 1;
      return img_height_reg;
   endfunction

   function automatic int unsigned active_h();
      if (h_factor_reg == 0) return 1;
      if (h_factor_reg > MAX_H_FACTOR) return MAX_H_FACTOR;
      return h_factor_reg;
   endfunction

   function automatic int unsigned active_v();
      if (v_factor_reg == 0) return 1;
      if (v_factor_reg > DEF_MAX_V_FACTOR) return DEF_MAX_V_FACTOR;
      return v_factor_reg;
   endfunction

   function automatic logic [31:0] reg_value(input csr_index_type idx);
      case (idx)
         REG_IMAGE_WIDTH:  return {20'd0, img_width_reg};
         REG_IMAGE_HEIGHT: return {16'd0, img_height_reg};
         REG_H_FACTOR:     return {29'd0, h_factor_reg};
         REG_V_FACTOR:     return {29'd0, v_factor_reg};
         default:          return '0;
      endcase
   endfunction

   // Work out the result word for one accepted request word.
   task automatic mcu_order_step(input cmd_type cmd, input logic [7:0] red, green, blue);
      int unsigned  w, h, v, col, row, mcu_w, n_mcu, rows, x, y, blk_idx;
      logic [23:0]  pix;
      rsp_word_type want;
      w = active_width();
      h = active_h();
      v = active_v();
      want = '0;
      if (cmd == CMD_WRITE) begin
         if (reading) begin
            want.meta.status = ST_REFUSED;
         end else begin
            col = (wr_col < w) ? wr_col : w - 1;
            row = (strip_rows < STRIP_ROWS) ? strip_rows : STRIP_ROWS - 1;
            strip_mem[row * DEF_MAX_WIDTH + col] = {red, green, blue};
            want.meta.status = ST_ACCEPTED;
            wr_col++;
            if (wr_col >= w) begin
               wr_col = 0;
               strip_rows++;
               img_rows++;
               if (strip_rows >= BLOCK_SIDE * v || img_rows >= active_height()) begin
                  reading = 1'b1;
                  mcu_col = 0;
                  blk_row = 0;
                  blk_col = 0;
                  pix_row = 0;
                  pix_col = 0;
               end
            end
         end
      end else if (!reading) begin
         want.meta.status = ST_NOT_READY;
      end else begin
         mcu_w = BLOCK_SIDE * h;
         n_mcu = (w + mcu_w - 1) / mcu_w;
         rows = (strip_rows < 1) ? 1 : (strip_rows > STRIP_ROWS) ? STRIP_ROWS : strip_rows;
         // edge padding: clamp to last column / last written row
         x = mcu_col * mcu_w + blk_col * BLOCK_SIDE + pix_col;
         y = blk_row * BLOCK_SIDE + pix_row;
         if (x > w - 1) x = w - 1;
         if (y > rows - 1) y = rows - 1;
         pix = strip_mem[y * DEF_MAX_WIDTH + x];
         want.meta.status = ST_DELIVERED;
         {want.red, want.green, want.blue} = pix;
         blk_idx = blk_row * h + blk_col;
         want.meta.block_number = blk_idx[3:0];
         pix_col++;
         if (pix_col >= BLOCK_SIDE) begin
            pix_col = 0;
            pix_row++;
            if (pix_row >= BLOCK_SIDE) begin
               pix_row = 0;
               want.meta.end_of_block = 1'b1;
               blk_col++;
               if (blk_col >= h) begin
                  blk_col = 0;
                  blk_row++;
                  if (blk_row >= v) begin
                     blk_row = 0;
                     want.meta.end_of_mcu = 1'b1;
                     mcu_col++;
                     if (mcu_col >= n_mcu) begin
                        mcu_col = 0;
                        reading = 1'b0;
                        strip_rows = 0;
                        wr_col = 0;
                        if (img_rows >= active_height()) begin
                           want.meta.end_of_image = 1'b1;
                           img_rows = '0;
                           images_done++;
                        end
                     end
                  end
               end
            end
         end
      end
      expected_words.push_back(want);
   endtask

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: result word with none expected, got status %0d", $time, rsp_status);
            errors++;
         end else begin
            want = expected_words.pop_front();
            check_field("status", 8'(want.meta.status), 8'(rsp_status));
            check_field("red", want.red, rsp_red_out);
            check_field("green", want.green, rsp_green_out);
            check_field("blue", want.blue, rsp_blue_out);
            check_field("block_number", 8'(want.meta.block_number), 8'(rsp_block_number));
            check_field("end_of_block", 8'(want.meta.end_of_block), 8'(rsp_end_of_block));
            check_field("end_of_mcu", 8'(want.meta.end_of_mcu), 8'(rsp_end_of_mcu));
            check_field("end_of_image", 8'(want.meta.end_of_image), 8'(rsp_end_of_image));
         end
      end
   end

   // receiver: rotating stall pattern, plus long hold-offs on request
   initial begin : result_drain
      logic [31:0] pattern;
      int unsigned age;
      rsp_ready = 1'b0;
      pattern = '1;
      age = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_ready = 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         if (age == 0) begin
            age = 32;
            case ($urandom_range(0, 3))
               0:       pattern = '1;
               1:       pattern = $urandom;
               default: pattern = $urandom | $urandom;
            endcase
         end
         age--;
         rsp_ready = pattern[0];
         pattern = {pattern[0], pattern[31:1]};
      end
   end

   task automatic send_word(input cmd_type cmd, input logic [7:0] red, green, blue);
      if (sender_idles) begin
         if (burst_left == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_valid    = 1'b1;
      req_cmd      = cmd;
      req_red_in   = red;
      req_green_in = green;
      req_blue_in  = blue;
      do @(posedge clock); while (!req_ready);
      mcu_order_step(cmd, red, green, blue);
      items_sent++;
      @(negedge clock);
   endtask

   // mostly the command the current phase wants; noise_pct percent the other one
   task automatic send_random(input int unsigned noise_pct);
      logic    odd;
      cmd_type cmd;
      odd = ($urandom_range(0, 99) < noise_pct);
      cmd = (reading ^ odd) ? CMD_FETCH : CMD_WRITE;
      send_word(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic run_image(input int unsigned noise_pct);
      int unsigned start;
      start = images_done;
      while (images_done == start) send_random(noise_pct);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   task automatic csr_check(input csr_index_type idx);
      logic [31:0] want;
      wait_drained();
      want   = reg_value(idx);
      psel   = 1'b1;
      pwrite = 1'b0;
      paddr  = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $display("%0t: register %0d readback, expected %0h, got %0h", $time, idx, want, prdata);
         errors++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [31:0] value);
      wait_drained();
      psel   = 1'b1;
      pwrite = 1'b1;
      paddr  = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_IMAGE_WIDTH:  img_width_reg  = value[11:0];
         REG_IMAGE_HEIGHT: img_height_reg = value[15:0];
         REG_H_FACTOR:     h_factor_reg   = value[2:0];
         REG_V_FACTOR:     v_factor_reg   = value[2:0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      csr_check(idx);
   endtask

   task automatic set_geometry(input logic [31:0] width, height, hf, vf);
      csr_write(REG_IMAGE_WIDTH, width);
      csr_write(REG_IMAGE_HEIGHT, height);
      csr_write(REG_H_FACTOR, hf);
      csr_write(REG_V_FACTOR, vf);
   endtask

   function automatic logic [31:0] random_factor();
      if ($urandom_range(0, 3) == 0) return 32'd0;
      return $urandom_range(1, 2);
   endfunction

   // reset defaults: 8x8 image, one block per MCU
   task automatic test_default_image();
      for (int i = 0; i < 4; i++) csr_check(csr_index_type'(i));
      send_word(CMD_FETCH, 8'hFF, 8'hFF, 8'hFF);  // nothing stored yet
      for (int i = 0; i < 64; i++) begin
         if (i == 0) send_word(CMD_WRITE, 8'h00, 8'h00, 8'h00);
         else if (i == 1) send_word(CMD_WRITE, 8'hFF, 8'hFF, 8'hFF);
         else send_random(0);
      end
      send_word(CMD_WRITE, 8'hA5, 8'h5A, 8'hC3);  // strip busy, refused
      while (reading) send_random(0);
   endtask

   // zero and oversized register values act as the nearest legal one
   task automatic test_register_limits();
      set_geometry(0, 0, 7, 0);
      run_image(0);
      set_geometry(3, 2, 0, 7);
      run_image(3);
   endtask

   // tall image, height lowered below the rows already written
   task automatic test_tall_image();
      set_geometry(3, 32'hFFFF, 1, 1);
      while (img_rows < 16) send_random(5);
      while (reading) send_random(5);
      csr_write(REG_IMAGE_HEIGHT, 5);
      run_image(5);
   endtask

   // v and h lowered part way through a strip
   task automatic test_mid_strip_changes();
      set_geometry(5, 40, 2, 2);
      while (strip_rows < 9) send_random(0);
      csr_write(REG_V_FACTOR, 1);
      while (!reading) send_random(0);
      repeat (20) send_random(0);
      csr_write(REG_H_FACTOR, 1);
      while (reading) send_random(0);
      csr_write(REG_IMAGE_HEIGHT, 11);
      run_image(5);
   endtask

   // receiver holds off while words keep coming, so the input must stall
   task automatic test_receiver_holdoff();
      set_geometry(8, 8, 1, 1);
      sender_idles = 1'b0;
      hold_cycles  = 300;
      run_image(0);
      sender_idles = 1'b1;
   endtask

   // oversized width reads back as written
   task automatic test_max_width();
      csr_write(REG_IMAGE_WIDTH, 32'hFFF);
   endtask

   task automatic test_random_images();
      int unsigned start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         set_geometry($urandom_range(0, 12), $urandom_range(0, 10),
                      random_factor(), random_factor());
         sender_idles = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 2)) run_image(10);
      end
      sender_idles = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = CMD_WRITE;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_image();
      test_register_limits();
      test_tall_image();
      test_mid_strip_changes();
      test_receiver_holdoff();
      test_max_width();
      test_random_images();

      wait_drained();
      repeat (8) @(negedge clock);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("raster_to_mcu_block_reorder test passed");
      end else begin
         $display("raster_to_mcu_block_reorder test failed");
      end
      $finish;
   end

endmodule
